FILE: sv/dsls_pkg.sv
// ----------------------------------------------------------------------------
// dsls_pkg
// Shared widths, register indexes and reset values for the SCAN/LOOK
// seek scheduler.
// ----------------------------------------------------------------------------
package dsls_pkg;

  localparam int POS_BITS      = 16;
  localparam int TOTAL_BITS    = 22;
  localparam int CFG_DATA_BITS = 17;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [TOTAL_BITS-1:0]    TOTAL_MAX          = '1;
  localparam logic [POS_BITS-1:0]      START_HEAD_RESET   = 16'd185;
  localparam logic [CFG_DATA_BITS-1:0] CYL_COUNT_RESET    = 17'd500;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SWEEP_MODE     = 2'd0,
    CFG_START_HEAD     = 2'd1,
    CFG_CYLINDER_COUNT = 2'd2
  } cfg_index_t;

  // sweep_mode encoding
  localparam logic MODE_SCAN = 1'b0;

endpackage

FILE: sv/dsls_ram.sv
// ----------------------------------------------------------------------------
// dsls_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dsls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/disk_scan_look_seek_scheduler.sv
// ----------------------------------------------------------------------------
// disk_scan_look_seek_scheduler
// Elevator (SCAN / LOOK) seek scheduler over a batch of cylinder requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on in_cylinder / in_last_request, one word taken at each
//   clock edge with start high and busy low, so a batch loads at one request
//   per cycle. Requests past MAX_REQUESTS are dropped and flag overflow on
//   every result of that batch; the word marked last still closes the batch.
//   After the last word busy goes high while the batch is insertion sorted in
//   the request RAM, the split point is found and the sweep runs. All passes
//   use the one RAM read port, so after the last word the block is busy for
//   the sorting, the split search, a read, distance and total add step for
//   each visited position, and a wrap-up.
//   Each visited position shows on the out_ ports for one cycle with
//   out_valid high; the receiver cannot stall and must take it then.
//   out_end_of_run marks the final position of the batch.
//   The user must write configuration (cfg_we/cfg_index/cfg_wdata) only
//   while busy is low; the block itself does not enforce it.
//   A synchronous reset (rst_n low) restores the register defaults
//   (SCAN, head 185, 500 cylinders) and empties the batch.
// ----------------------------------------------------------------------------
module disk_scan_look_seek_scheduler
  import dsls_pkg::*;
#(
  parameter int MAX_REQUESTS = 32,
  parameter int CYL_BITS     = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [POS_BITS-1:0]      in_cylinder,
  input  logic                     in_last_request,
  output logic                     out_valid,
  output logic [POS_BITS-1:0]      out_position,
  output logic [TOTAL_BITS-1:0]    out_movement_total,
  output logic                     out_end_of_run,
  output logic                     out_overflow,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int SW = (CYL_BITS < POS_BITS) ? CYL_BITS : POS_BITS;
  localparam int AW = $clog2(MAX_REQUESTS);
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SORT_I, ST_SORT_V, ST_SORT_J, ST_SORT_CMP,
    ST_SPLIT_RD, ST_SPLIT_CMP, ST_ASC_RD, ST_ASC_DAT, ST_END,
    ST_DESC_RD, ST_DESC_DAT, ST_EMIT, ST_DONE
  } state_t;

  typedef enum logic [1:0] {PH_ASC, PH_END, PH_DESC} phase_t;

  // configuration registers
  logic                     mode_r;
  logic [POS_BITS-1:0]      start_head_r;
  logic [CFG_DATA_BITS-1:0] cyl_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_SCAN;
      start_head_r <= START_HEAD_RESET;
      cyl_count_r  <= CYL_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SWEEP_MODE:     mode_r       <= cfg_wdata[0];
        CFG_START_HEAD:     start_head_r <= cfg_wdata[POS_BITS-1:0];
        CFG_CYLINDER_COUNT: cyl_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        split_r, split_nxt;
  logic [SW-1:0]        v_r, v_nxt;
  logic                 dropped_r, dropped_nxt;
  logic                 scan_r, scan_nxt;
  logic [POS_BITS-1:0]  end_stop_r, end_stop_nxt;
  logic [POS_BITS-1:0]  head_r, head_nxt;
  logic [POS_BITS-1:0]  tgt_r, tgt_nxt;
  logic [POS_BITS-1:0]  diff_r, diff_nxt;
  logic                 fin_r, fin_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_fin_r, out_fin_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [SW-1:0]        ram_rdata;

  logic                 accept;
  logic [POS_BITS-1:0]  visit_tgt;
  logic [CFG_DATA_BITS-1:0] stop_m1;
  logic [TOTAL_BITS:0]  sum;

  assign accept = start && (state_r == ST_IDLE);

  // target, end stop and running-total sum for the visit being set up
  assign visit_tgt = (state_r == ST_END) ? end_stop_r : POS_BITS'(ram_rdata);
  assign stop_m1   = (cyl_count_r == '0) ? '0 : cyl_count_r - 1'b1;
  assign sum       = {1'b0, total_r} + (TOTAL_BITS + 1)'(diff_r);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    split_nxt     = split_r;
    v_nxt         = v_r;
    dropped_nxt   = dropped_r;
    scan_nxt      = scan_r;
    end_stop_nxt  = end_stop_r;
    head_nxt      = head_r;
    tgt_nxt       = tgt_r;
    diff_nxt      = diff_r;
    fin_nxt       = fin_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_fin_nxt   = out_fin_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = in_cylinder[SW-1:0];
    ram_raddr     = k_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_r < MAX_CNT) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last_request) begin
            n_nxt        = (cnt_r < MAX_CNT) ? cnt_r + 1'b1 : cnt_r;
            i_nxt        = CW'(1);
            head_nxt     = start_head_r;
            total_nxt    = '0;
            scan_nxt     = (mode_r == MODE_SCAN);
            end_stop_nxt = stop_m1[POS_BITS] ? '1 : stop_m1[POS_BITS-1:0];
            state_nxt    = ST_SORT_I;
          end
        end
      end
      ST_SORT_I: begin
        ram_raddr = i_r[AW-1:0];
        if (i_r >= n_r) begin
          k_nxt     = '0;
          state_nxt = ST_SPLIT_RD;
        end else begin
          state_nxt = ST_SORT_V;
        end
      end
      ST_SORT_V: begin
        v_nxt     = ram_rdata;
        j_nxt     = i_r;
        state_nxt = ST_SORT_J;
      end
      ST_SORT_J: begin
        ram_raddr = AW'(j_r - 1'b1);
        if (j_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = j_r[AW-1:0];
          ram_wdata = v_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SORT_I;
        end else begin
          state_nxt = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[AW-1:0];
        if (ram_rdata > v_r) begin
          ram_wdata = ram_rdata;
          j_nxt     = j_r - 1'b1;
          state_nxt = ST_SORT_J;
        end else begin
          ram_wdata = v_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SORT_I;
        end
      end
      ST_SPLIT_RD: begin
        if (k_r == n_r) begin
          split_nxt = k_r;
          state_nxt = ST_ASC_RD;
        end else begin
          state_nxt = ST_SPLIT_CMP;
        end
      end
      ST_SPLIT_CMP: begin
        if (POS_BITS'(ram_rdata) < head_r) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_SPLIT_RD;
        end else begin
          split_nxt = k_r;
          state_nxt = ST_ASC_RD;
        end
      end
      ST_ASC_RD: begin
        if (k_r == n_r) begin
          if (scan_r) begin
            state_nxt = ST_END;
          end else begin
            k_nxt     = split_r;
            state_nxt = ST_DESC_RD;
          end
        end else begin
          state_nxt = ST_ASC_DAT;
        end
      end
      ST_ASC_DAT: begin
        tgt_nxt   = visit_tgt;
        diff_nxt  = (visit_tgt >= head_r) ? visit_tgt - head_r : head_r - visit_tgt;
        fin_nxt   = ((k_r + 1'b1) == n_r) && !scan_r && (split_r == '0);
        phase_nxt = PH_ASC;
        state_nxt = ST_EMIT;
      end
      ST_END: begin
        tgt_nxt   = visit_tgt;
        diff_nxt  = (visit_tgt >= head_r) ? visit_tgt - head_r : head_r - visit_tgt;
        fin_nxt   = (split_r == '0);
        phase_nxt = PH_END;
        state_nxt = ST_EMIT;
      end
      ST_DESC_RD: begin
        ram_raddr = AW'(k_r - 1'b1);
        state_nxt = (k_r == '0) ? ST_DONE : ST_DESC_DAT;
      end
      ST_DESC_DAT: begin
        tgt_nxt   = visit_tgt;
        diff_nxt  = (visit_tgt >= head_r) ? visit_tgt - head_r : head_r - visit_tgt;
        fin_nxt   = (k_r == CW'(1));
        phase_nxt = PH_DESC;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        total_nxt     = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
        head_nxt      = tgt_r;
        out_valid_nxt = 1'b1;
        out_fin_nxt   = fin_r;
        unique case (phase_r)
          PH_ASC: begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_ASC_RD;
          end
          PH_END: begin
            k_nxt     = split_r;
            state_nxt = ST_DESC_RD;
          end
          PH_DESC: begin
            k_nxt     = k_r - 1'b1;
            state_nxt = ST_DESC_RD;
          end
          default: state_nxt = ST_DESC_RD;
        endcase
      end
      ST_DONE: begin
        cnt_nxt     = '0;
        dropped_nxt = 1'b0;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      head_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dropped_r   <= dropped_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    phase_r    <= phase_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    split_r    <= split_nxt;
    v_r        <= v_nxt;
    scan_r     <= scan_nxt;
    end_stop_r <= end_stop_nxt;
    tgt_r      <= tgt_nxt;
    diff_r     <= diff_nxt;
    fin_r      <= fin_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  dsls_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_REQUESTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_position       = head_r;
  assign out_movement_total = total_r;
  assign out_end_of_run     = out_valid_r && out_fin_r;
  assign out_overflow       = dropped_r;

  // results only come out of a running sweep
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result word while idle");

  // store fill never passes its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("request count past store depth");

  // a word taken with the store full flags overflow
  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && cnt_r == MAX_CNT) |=> dropped_r)
    else $error("dropped request not flagged");

  // the final word of a run is followed by return to idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_end_of_run |-> ##[2:3] !busy)
    else $error("block still busy after end of run");

  // running total never decreases within a run
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(busy) && state_r != ST_DONE && !$past(out_end_of_run))
      |-> out_movement_total >= $past(total_r))
    else $error("movement total went down");

endmodule
